@@ rtl/core/assert_macros.svh @@
// Assertion macros for the RTL of the service queue.
// No dependencies; the bodies drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check an implication property on every rising edge outside reset.
`define FMVQ_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define FMVQ_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define FMVQ_ASSERT(name, clk, rst_n, prop, msg)
`define FMVQ_NEVER(name, clk, rst_n, cond, msg)
`endif
`endif

@@ rtl/core/fmvq_pkg.sv @@
// Shared types, codes and ring helpers for the service queue.
// No dependencies; used by the top level of the service queue and the testbench.
`default_nettype none
package fmvq_pkg;

  localparam int unsigned Capacity = 256;
  localparam int unsigned SlotW    = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CountW   = $clog2(Capacity + 1);

  // Item kinds
  localparam logic [1:0] KIND_ARRIVE  = 2'd0;
  localparam logic [1:0] KIND_OLDEST  = 2'd1;
  localparam logic [1:0] KIND_LARGEST = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_STORED = 2'd0;
  localparam logic [1:0] STATUS_SERVED = 2'd1;
  localparam logic [1:0] STATUS_EMPTY  = 2'd2;
  localparam logic [1:0] STATUS_FULL   = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] amount;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] served_id;
  } out_word_t;

  // One ring slot as held in the slot memory
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] amount;
  } slot_t;

  function automatic logic [SlotW-1:0] slot_next(input logic [SlotW-1:0] s);
    return (s == SlotW'(Capacity - 1)) ? '0 : s + SlotW'(1);
  endfunction

  function automatic logic [SlotW-1:0] slot_prev(input logic [SlotW-1:0] s);
    return (s == '0) ? SlotW'(Capacity - 1) : s - SlotW'(1);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/fifo_and_max_value_service_queue.sv @@
// Service queue: entries arrive with an amount and get sequential numbers from 1;
// they leave either oldest first or largest amount first (ties to the earliest).
// Entries sit in a ring of Capacity slots whose ids and amounts live in one slot
// memory with a registered read; per-slot valid bits are flip-flops cleared by reset,
// so no clearing pass is needed. An arrive, a rejected arrive and a serve on an empty
// store answer in the cycle after acceptance. A serve reads ring slots through the
// single read port of the slot memory, one ring slot per cycle: the head slot alone for
// a serve-oldest, the whole occupied span for a serve-largest. It then drops holes from
// the head end and the tail end of the span and answers once the output register frees.
// The input stalls while a serve is in progress and while the output register holds a
// word that the receiver has not taken.
// A serve on an empty store returns status empty; an arrive on a full ring (holes
// count as used) returns status full and consumes no number. Kind 3 acts as largest.
// Depends on fmvq_pkg, fmvq_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module fifo_and_max_value_service_queue
  import fmvq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_stall_o,
  input  wire in_word_t  in_data_i,
  output      logic      out_valid_o,
  input  wire logic      out_stall_i,
  output      out_word_t out_data_o
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_SCAN      = 3'd1;
  localparam logic [2:0] ST_TRIM_HEAD = 3'd2;
  localparam logic [2:0] ST_TRIM_TAIL = 3'd3;
  localparam logic [2:0] ST_FINISH    = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [Capacity-1:0] valid_q, valid_d;
  logic [31:0]         next_q, next_d;
  logic [SlotW-1:0]    head_q, head_d;
  logic [SlotW-1:0]    tail_q, tail_d;
  logic [CountW-1:0]   span_q, span_d;

  logic [SlotW-1:0]    scan_slot_q, scan_slot_d;
  logic [CountW-1:0]   scan_left_q, scan_left_d;
  logic                rd_pend_q, rd_pend_d;
  logic                rd_ok_q, rd_ok_d;
  logic [SlotW-1:0]    rd_slot_q, rd_slot_d;
  logic                found_q, found_d;
  logic [31:0]         best_amt_q, best_amt_d;
  logic [31:0]         best_id_q, best_id_d;
  logic [SlotW-1:0]    pick_q, pick_d;

  logic                out_valid_q, out_valid_d;
  out_word_t           out_data_q, out_data_d;

  logic                ram_we;
  slot_t               ram_wdata;
  slot_t               ram_rdata;
  logic                in_acc;
  logic                out_free;
  logic [SlotW-1:0]    tail_prev;

  fmvq_ram #(
    .Width($bits(slot_t)),
    .Depth(Capacity)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(ram_wdata),
    .raddr_i(scan_slot_q),
    .rdata_o(ram_rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tail_prev  = slot_prev(tail_q);
  assign ram_wdata  = '{id: next_q, amount: in_data_i.amount};

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Next-state logic: accept, scan, trim, deliver
  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    next_d      = next_q;
    head_d      = head_q;
    tail_d      = tail_q;
    span_d      = span_q;
    scan_slot_d = scan_slot_q;
    scan_left_d = scan_left_q;
    rd_pend_d   = 1'b0;
    rd_ok_d     = rd_ok_q;
    rd_slot_d   = rd_slot_q;
    found_d     = found_q;
    best_amt_d  = best_amt_q;
    best_id_d   = best_id_q;
    pick_d      = pick_q;
    ram_we      = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.kind == KIND_ARRIVE) begin
            if (span_q == CountW'(Capacity)) begin
              out_valid_d = 1'b1;
              out_data_d  = '{status: STATUS_FULL, served_id: 32'd0};
            end else begin
              // Store the word at the tail and number it
              ram_we          = 1'b1;
              valid_d[tail_q] = 1'b1;
              tail_d          = slot_next(tail_q);
              span_d          = span_q + CountW'(1);
              next_d          = next_q + 32'd1;
              out_valid_d     = 1'b1;
              out_data_d      = '{status: STATUS_STORED, served_id: next_q};
            end
          end else if (span_q == '0) begin
            out_valid_d = 1'b1;
            out_data_d  = '{status: STATUS_EMPTY, served_id: 32'd0};
          end else begin
            // Oldest is a scan of the head slot alone, which is always valid
            scan_slot_d = head_q;
            scan_left_d = (in_data_i.kind == KIND_OLDEST) ? CountW'(1) : span_q;
            found_d     = 1'b0;
            state_d     = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue one slot read per cycle
        if (scan_left_q != '0) begin
          rd_pend_d   = 1'b1;
          rd_ok_d     = valid_q[scan_slot_q];
          rd_slot_d   = scan_slot_q;
          scan_slot_d = slot_next(scan_slot_q);
          scan_left_d = scan_left_q - CountW'(1);
        end
        // Compare the returned slot; strict greater keeps the earliest on ties
        if (rd_pend_q && rd_ok_q && (!found_q || ram_rdata.amount > best_amt_q)) begin
          found_d    = 1'b1;
          best_amt_d = ram_rdata.amount;
          best_id_d  = ram_rdata.id;
          pick_d     = rd_slot_q;
        end
        if (scan_left_q == '0 && !rd_pend_q) begin
          valid_d[pick_q] = 1'b0;
          state_d         = ST_TRIM_HEAD;
        end
      end

      ST_TRIM_HEAD: begin
        // Drop holes at the head
        if (span_q != '0 && !valid_q[head_q]) begin
          head_d = slot_next(head_q);
          span_d = span_q - CountW'(1);
        end else begin
          state_d = ST_TRIM_TAIL;
        end
      end

      ST_TRIM_TAIL: begin
        // Drop holes at the tail end
        if (span_q != '0 && !valid_q[tail_prev]) begin
          tail_d = tail_prev;
          span_d = span_q - CountW'(1);
        end else begin
          if (span_q == '0) begin
            head_d = tail_q;
          end
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        // Hold the result until the output register frees
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '{status: STATUS_SERVED, served_id: best_id_q};
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      next_q      <= 32'd1;
      head_q      <= '0;
      tail_q      <= '0;
      span_q      <= '0;
      scan_left_q <= '0;
      rd_pend_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      next_q      <= next_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      span_q      <= span_d;
      scan_left_q <= scan_left_d;
      rd_pend_q   <= rd_pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    scan_slot_q <= scan_slot_d;
    rd_ok_q     <= rd_ok_d;
    rd_slot_q   <= rd_slot_d;
    best_amt_q  <= best_amt_d;
    best_id_q   <= best_id_d;
    pick_q      <= pick_d;
    out_data_q  <= out_data_d;
  end

  // Checks
  `FMVQ_NEVER(a_span_bound, clk_i, rst_ni, span_q > CountW'(Capacity), "span exceeds capacity")
  `FMVQ_ASSERT(a_head_valid, clk_i, rst_ni, (state_q == ST_IDLE && span_q != '0) |-> valid_q[head_q], "head slot is a hole while idle")
  `FMVQ_ASSERT(a_empty_aligned, clk_i, rst_ni, (state_q == ST_IDLE && span_q == '0) |-> head_q == tail_q, "empty span with head and tail apart")
  `FMVQ_ASSERT(a_number_on_store, clk_i, rst_ni, (next_q != $past(next_q)) |-> (out_valid_o && out_data_o.status == STATUS_STORED), "arrival number consumed without a stored word")

endmodule
`default_nettype wire

@@ rtl/core/fmvq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fmvq_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  wire logic                           clk_i,
  input  wire logic                           we_i,
  input  wire logic [$clog2(Depth)-1:0]       waddr_i,
  input  wire logic [Width-1:0]               wdata_i,
  input  wire logic [$clog2(Depth)-1:0]       raddr_i,
  output      logic [Width-1:0]               rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for fifo_and_max_value_service_queue: arrive, serve-oldest and
// serve-largest words are checked against an in-bench ring predictor under random idling.
// Depends on fmvq_pkg and the RTL of the service queue.
`timescale 1ns / 1ps
module tb_top;
  import fmvq_pkg::*;

  // Kind value 3 is unused in the package; the block treats it as serve largest
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned DrainCycles = 600;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_data_o;

  fifo_and_max_value_service_queue u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Ring image of the store
  bit          ring_used [Capacity];
  logic [31:0] ring_id   [Capacity];
  logic [31:0] ring_amt  [Capacity];
  logic [31:0] next_id = 32'd1;
  int unsigned ring_head = 0;
  int unsigned ring_tail = 0;
  int unsigned ring_span = 0;

  out_word_t   pending_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned n_stored = 0, n_served = 0, n_empty = 0, n_full = 0;

  // Work out the result of one word and advance the ring image
  function automatic out_word_t queue_outcome(input in_word_t w);
    out_word_t   r;
    int unsigned pick;
    int unsigned s;
    logic [31:0] best;
    bit          found;
    r = '0;
    if (w.kind == KIND_ARRIVE) begin
      if (ring_span >= Capacity) begin
        r.status = STATUS_FULL;
        n_full++;
      end else begin
        ring_used[ring_tail] = 1'b1;
        ring_id[ring_tail]   = next_id;
        ring_amt[ring_tail]  = w.amount;
        ring_tail = (ring_tail + 1) % Capacity;
        ring_span++;
        r.status    = STATUS_STORED;
        r.served_id = next_id;
        next_id     = next_id + 32'd1;
        n_stored++;
      end
    end else if (ring_span == 0) begin
      r.status = STATUS_EMPTY;
      n_empty++;
    end else begin
      pick = ring_head;
      if (w.kind != KIND_OLDEST) begin
        found = 1'b0;
        best  = '0;
        s     = ring_head;
        for (int unsigned n = 0; n < ring_span; n++) begin
          if (ring_used[s] && (!found || ring_amt[s] > best)) begin
            found = 1'b1;
            best  = ring_amt[s];
            pick  = s;
          end
          s = (s + 1) % Capacity;
        end
      end
      r.status    = STATUS_SERVED;
      r.served_id = ring_id[pick];
      ring_used[pick] = 1'b0;
      // Drop holes at both ends of the span
      while (ring_span > 0 && !ring_used[ring_head]) begin
        ring_head = (ring_head + 1) % Capacity;
        ring_span--;
      end
      while (ring_span > 0 && !ring_used[(ring_tail + Capacity - 1) % Capacity]) begin
        ring_tail = (ring_tail + Capacity - 1) % Capacity;
        ring_span--;
      end
      if (ring_span == 0) ring_head = ring_tail;
      n_served++;
    end
    return r;
  endfunction

  // Offer one word, idling at random first; valid stays high after acceptance
  task automatic send_word(input logic [1:0] kind, input logic [31:0] amount);
    in_word_t w;
    w.kind   = kind;
    w.amount = amount;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(queue_outcome(w));
    words_sent++;
  endtask

  // Hold the input idle until every expected result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_amount();
    return ($urandom_range(1) == 0) ? 32'($urandom_range(15)) : 32'($urandom());
  endfunction

  // Serves on an empty store, including the unused kind
  task automatic test_empty_serves();
    send_word(KIND_OLDEST, 32'hFFFF_FFFF);
    send_word(KIND_LARGEST, 32'd0);
    send_word(KIND_UNUSED, 32'h1234_5678);
    wait_drained();
  endtask

  // Amount extremes, ties to the earliest arrival, and hole trimming at the head
  task automatic test_order_and_ties();
    send_word(KIND_ARRIVE, 32'd0);
    send_word(KIND_ARRIVE, 32'hFFFF_FFFF);
    send_word(KIND_ARRIVE, 32'hFFFF_FFFF);
    send_word(KIND_ARRIVE, 32'hAAAA_AAAA);
    send_word(KIND_ARRIVE, 32'h5555_5555);
    send_word(KIND_LARGEST, 32'd0);
    send_word(KIND_UNUSED, 32'd0);
    send_word(KIND_OLDEST, 32'd0);
    send_word(KIND_OLDEST, 32'd0);
    send_word(KIND_LARGEST, 32'd0);
    send_word(KIND_ARRIVE, 32'd7);
    send_word(KIND_ARRIVE, 32'd7);
    send_word(KIND_LARGEST, 32'd0);
    send_word(KIND_OLDEST, 32'd0);
    send_word(KIND_OLDEST, 32'd0);
    send_word(KIND_LARGEST, 32'd0);
    wait_drained();
  endtask

  // Fill the ring and hit the full flag with holes inside the span; the ring stays
  // nearly full for the later tests, so they keep running into the full flag
  task automatic test_full_ring();
    for (int i = 0; i < Capacity + 2; i++) send_word(KIND_ARRIVE, 32'($urandom_range(7)));
    repeat (3) send_word(KIND_LARGEST, 32'd0);
    send_word(KIND_ARRIVE, 32'd3);
    repeat (2) send_word(KIND_OLDEST, 32'd0);
    repeat (3) send_word(KIND_ARRIVE, 32'($urandom_range(7)));
    send_word(KIND_LARGEST, 32'd0);
    wait_drained();
  endtask

  // Stall the output for a long stretch while words keep coming
  task automatic test_backpressure();
    hold_left <= 300;
    for (int i = 0; i < 40; i++)
      send_word((i % 3 == 2) ? KIND_LARGEST : KIND_ARRIVE, pick_amount());
    wait_drained();
  endtask

  // Random mix, arrivals about half of the words, so the store grows and shrinks
  task automatic test_random(input int unsigned count);
    int unsigned r;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 50)      send_word(KIND_ARRIVE, pick_amount());
      else if (r < 72) send_word(KIND_OLDEST, 32'($urandom()));
      else if (r < 95) send_word(KIND_LARGEST, 32'($urandom()));
      else             send_word(KIND_UNUSED, 32'($urandom()));
    end
    wait_drained();
  endtask

  // Receiver stall: a counted hold-off, else random idling
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result word: status %0d served_id %0d",
               out_data_o.status, out_data_o.served_id);
        mismatches++;
      end else begin
        exp_w = pending_results.pop_front();
        if (out_data_o.status !== exp_w.status) begin
          $error("status: expected %0d, actual %0d", exp_w.status, out_data_o.status);
          mismatches++;
        end
        if (out_data_o.served_id !== exp_w.served_id) begin
          $error("served_id: expected %0d, actual %0d",
                 exp_w.served_id, out_data_o.served_id);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 17;
    recv_idle_pct = 66;
    test_empty_serves();
    test_order_and_ties();
    test_full_ring();
    test_random(25);

    send_idle_pct = 66;
    recv_idle_pct = 17;
    test_random(25);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(25);

    // Watch for stray result words before closing
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected result words never arrived", pending_results.size());
      mismatches++;
    end
    $display("Sent %0d words (%0d stored, %0d served, %0d empty serves, %0d full arrivals);",
             words_sent, n_stored, n_served, n_empty, n_full);
    $display("checked %0d results across ring fill, ties, holes and output back-pressure.",
             results_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5_000_000;
    $display("Timeout with %0d result words outstanding", pending_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/fmvq_pkg.sv
rtl/core/fmvq_ram.sv
rtl/core/fifo_and_max_value_service_queue.sv
tb/tb_top.sv
